FILE: src/urlqp_pkg.sv
// shared types and constants for the urlencoded query parser
`default_nettype none

package urlqp_pkg;

  // result kinds
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // special characters
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_EQ    = 8'h3d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       pair_ok;
    logic       string_done;
  } out_item_t;

  // work for the back end: an optional byte result, then an optional pair end
  typedef struct packed {
    logic       has_byte;
    logic [7:0] byte_val;
    logic [1:0] byte_kind;
    logic       has_end;
    logic       pair_ok;
    logic       string_done;
  } job_t;

endpackage

`default_nettype wire

FILE: src/urlqp_front.sv
// front end: classifies each input byte and builds a job for the back end
`default_nettype none

module urlqp_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire urlqp_pkg::in_item_t byte_data,
  output logic                    job_push,
  output urlqp_pkg::job_t         job,
  input  wire logic               job_full
);

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_VALUE = 2'd1,
    PH_PCT   = 2'd2,
    PH_DIGIT = 2'd3
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       value_seen, value_seen_next;
  logic       take;
  logic       dig_ok;
  logic [3:0] dig_val;

  // hex digit check: digits 0-9 and letters a-f and A-F only
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      return {1'b1, t[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      return {1'b1, t[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  assign byte_stall = job_full;
  assign take       = byte_valid && !job_full;
  assign {dig_ok, dig_val} = hex_decode(byte_data.in_byte);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    value_seen_next  = value_seen;
    job              = '0;
    if (byte_data.in_byte == urlqp_pkg::CHAR_AMP) begin
      job.has_end     = 1'b1;
      job.pair_ok     = (phase != PH_KEY) && value_seen;
      job.string_done = byte_data.in_last;
      phase_next       = PH_KEY;
      high_nibble_next = 4'd0;
      value_seen_next  = 1'b0;
    end else begin
      unique case (phase)
        PH_KEY: begin
          if (byte_data.in_byte == urlqp_pkg::CHAR_EQ) begin
            phase_next = PH_VALUE;
          end else begin
            job.has_byte  = 1'b1;
            job.byte_val  = byte_data.in_byte;
            job.byte_kind = urlqp_pkg::KIND_KEY;
          end
        end
        PH_VALUE: begin
          value_seen_next = 1'b1;
          job.byte_kind   = urlqp_pkg::KIND_VALUE;
          if (byte_data.in_byte == urlqp_pkg::CHAR_PLUS) begin
            job.has_byte = 1'b1;
            job.byte_val = urlqp_pkg::CHAR_SPACE;
          end else if (byte_data.in_byte == urlqp_pkg::CHAR_PCT) begin
            phase_next = PH_PCT;
          end else begin
            job.has_byte = 1'b1;
            job.byte_val = byte_data.in_byte;
          end
        end
        PH_PCT: begin
          value_seen_next = 1'b1;
          if (dig_ok) begin
            high_nibble_next = dig_val;
            phase_next       = PH_DIGIT;
          end else begin
            phase_next = PH_VALUE;
          end
        end
        PH_DIGIT: begin
          value_seen_next  = 1'b1;
          job.has_byte     = dig_ok;
          job.byte_val     = {high_nibble, dig_val};
          job.byte_kind    = urlqp_pkg::KIND_VALUE;
          high_nibble_next = 4'd0;
          phase_next       = PH_VALUE;
        end
        default: phase_next = PH_KEY;
      endcase
      // last byte closes the pair after its own handling
      if (byte_data.in_last) begin
        job.has_end      = 1'b1;
        job.pair_ok      = (phase_next != PH_KEY) && value_seen_next;
        job.string_done  = 1'b1;
        phase_next       = PH_KEY;
        high_nibble_next = 4'd0;
        value_seen_next  = 1'b0;
      end
    end
  end

  // bytes with no result never enter the queue
  assign job_push = take && (job.has_byte || job.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_KEY;
      high_nibble <= 4'd0;
      value_seen  <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      value_seen  <= value_seen_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/urlqp_queue.sv
// short job queue between front and back end
`default_nettype none

module urlqp_queue #(
  parameter int unsigned DEPTH = urlqp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire urlqp_pkg::job_t  push_job,
  output logic                  full,
  input  wire logic             pop,
  output urlqp_pkg::job_t       head_job,
  output logic                  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  urlqp_pkg::job_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/urlqp_back.sv
// back end: turns queued jobs into results through one output register
`default_nettype none

module urlqp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire urlqp_pkg::job_t   head_job,
  input  wire logic              job_empty,
  output logic                   job_pop,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output urlqp_pkg::out_item_t   res_data
);

  logic                 byte_sent;
  logic                 load;
  logic                 emit_byte;
  urlqp_pkg::out_item_t res_next;

  assign load      = !res_valid || !res_stall;
  assign emit_byte = head_job.has_byte && !byte_sent;
  // pop once the last result of the head job goes out
  assign job_pop   = load && !job_empty && !(emit_byte && head_job.has_end);

  always_comb begin
    res_next = '0;
    if (emit_byte) begin
      res_next.out_byte = head_job.byte_val;
      res_next.out_kind = head_job.byte_kind;
    end else begin
      res_next.out_kind    = urlqp_pkg::KIND_END;
      res_next.pair_ok     = head_job.pair_ok;
      res_next.string_done = head_job.string_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      byte_sent <= 1'b0;
    end else if (load) begin
      res_valid <= !job_empty;
      if (!job_empty) begin
        res_data  <= res_next;
        byte_sent <= emit_byte && head_job.has_end;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/urlencoded_query_parser.sv
// top level of the urlencoded query parser
`default_nettype none

// splits a form-urlencoded string, one byte per request, into key bytes,
// decoded value bytes and pair-end results. the front end takes one request
// per cycle while the job queue is not full and keeps the parse state (key,
// value, after '%', after first hex digit); the back end drains a short job
// queue through one output register. a byte that yields a byte result plus
// a pair end (the last byte of a string) sends two results, byte first,
// through the single output register of the back end, and the queue of
// QUEUE_DEPTH jobs absorbs those. bytes that yield nothing ('=' in a key,
// '%', the first escape digit, a bad escape digit) never reach the queue.
// a request's first result is registered in a queue slot and then in the
// output register. no clearing pass after reset.
module urlencoded_query_parser #(
  parameter int unsigned QUEUE_DEPTH = urlqp_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request channel
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire urlqp_pkg::in_item_t  byte_data,
  // result channel
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output urlqp_pkg::out_item_t      res_data
);

  // jobs from front to back
  logic            job_push;
  urlqp_pkg::job_t job_in;
  logic            job_full;
  logic            job_pop;
  urlqp_pkg::job_t job_head;
  logic            job_empty;

  // classify the request and update the parse state
  urlqp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .job_push   (job_push),
    .job        (job_in),
    .job_full   (job_full)
  );

  // decouples input stalls from output stalls
  urlqp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job_in),
    .full     (job_full),
    .pop      (job_pop),
    .head_job (job_head),
    .empty    (job_empty)
  );

  // emits byte result first, then pair end
  urlqp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (job_head),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire
